// ===== rtl/rlst_pkg.sv =====
package rlst_pkg;

  // table geometry
  localparam int MaxLoads = 64;
  localparam int AddrW    = $clog2(MaxLoads);
  localparam int CntW     = $clog2(MaxLoads + 1);

  // transaction modes
  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeFrame = 2'd1,
    ModeTick  = 2'd2,
    ModeQuery = 2'd3
  } mode_e;

  // result kinds
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindPoll  = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  // load status codes
  localparam logic [1:0] StsUndef = 2'd0;
  localparam logic [1:0] StsOff   = 2'd1;
  localparam logic [1:0] StsOn    = 2'd2;
  localparam logic [1:0] StsNone  = 2'd3;

  // relay status bytes
  localparam logic [7:0] ByteOff = 8'h00;
  localparam logic [7:0] ByteOn  = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] CfgLoadCount  = 2'd0;
  localparam logic [1:0] CfgStartDelay = 2'd1;
  localparam logic [1:0] CfgNormalWait = 2'd2;
  localparam logic [1:0] CfgRetryWait  = 2'd3;

  // configuration reset values
  localparam logic [7:0] StartDelayRst = 8'd10;
  localparam logic [7:0] NormalWaitRst = 8'd1;
  localparam logic [7:0] RetryWaitRst  = 8'd60;

  // static part of a table entry
  typedef struct packed {
    logic [7:0]  node;
    logic [7:0]  group;
    logic [7:0]  channel;
    logic        relay;
    logic [15:0] sm;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

// ===== rtl/relay_load_status_tracker.sv =====
// relay load status tracker: keeps a table of up to rlst_pkg::MaxLoads loads in a
// synchronous entry memory plus a status memory (registered reads); status
// valid bits make every entry read as undefined after reset, so no clearing pass
// is needed. one transaction is worked at a time. an entry write, a frame with the
// relay flag clear and a tick still waiting go straight to the done state when the
// transaction is taken; a relay status frame, a tick that is allowed to poll and a
// group query first walk the active entries one per cycle through the single read
// port (a tick stops at the first undefined entry). the next transaction can be
// taken in the cycle after the result is loaded. the result register decouples the
// sides: a new transaction is taken while the previous result still waits. the user
// must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i only while the
// block is idle; the block itself does not enforce this.
module relay_load_status_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [5:0]         entry_index_i,
  input  logic [7:0]         node_i,
  input  logic [7:0]         group_i,
  input  logic [7:0]         channel_i,
  input  logic               is_relay_i,
  input  logic signed [15:0] sm_id_i,
  input  logic [7:0]         status_byte_i,
  // result transactions
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [7:0]         poll_node_o,
  output logic [7:0]         poll_group_o,
  output logic [1:0]         group_status_o,
  output logic               frame_matched_o
);

  // configuration registers
  logic [6:0] load_count_q;
  logic [7:0] start_delay_q, normal_wait_q, retry_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q  <= '0;
      start_delay_q <= rlst_pkg::StartDelayRst;
      normal_wait_q <= rlst_pkg::NormalWaitRst;
      retry_wait_q  <= rlst_pkg::RetryWaitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlst_pkg::CfgLoadCount:  load_count_q  <= cfg_data_i[6:0];
        rlst_pkg::CfgStartDelay: start_delay_q <= cfg_data_i;
        rlst_pkg::CfgNormalWait: normal_wait_q <= cfg_data_i;
        rlst_pkg::CfgRetryWait:  retry_wait_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // active entry count, clipped to the table depth
  logic [rlst_pkg::CntW-1:0] n_act;
  assign n_act = (int'(load_count_q) < rlst_pkg::MaxLoads) ?
                 rlst_pkg::CntW'(load_count_q) : rlst_pkg::CntW'(rlst_pkg::MaxLoads);

  // control state
  rlst_pkg::state_e state_q, state_d;
  logic             in_acc, out_take, out_load;

  assign in_stall_o = (state_q != rlst_pkg::StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;
  assign out_load   = (state_q == rlst_pkg::StDone) && (!out_valid_o || !out_stall_i);

  // captured transaction
  rlst_pkg::mode_e mode_q;
  logic [7:0]      node_q, group_q, chan_q, sbyte_q;
  logic [15:0]     sm_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= rlst_pkg::mode_e'(mode_i);
      node_q  <= node_i;
      group_q <= group_i;
      chan_q  <= channel_i;
      sbyte_q <= status_byte_i;
      sm_q    <= sm_id_i;
    end
  end

  // entry write on accept
  logic wr_entry;
  assign wr_entry = in_acc && (rlst_pkg::mode_e'(mode_i) == rlst_pkg::ModeWrite) &&
                    (int'(entry_index_i) < rlst_pkg::MaxLoads);

  logic [rlst_pkg::AddrW-1:0] wr_addr;
  assign wr_addr = rlst_pkg::AddrW'(entry_index_i);

  rlst_pkg::entry_t wr_entry_data;
  assign wr_entry_data = '{node: node_i, group: group_i, channel: channel_i,
                           relay: is_relay_i, sm: sm_id_i};

  // scan read pointer and processing stage
  logic [rlst_pkg::CntW-1:0]  rd_idx_q, rd_idx_d;
  logic                       pv_q, pv_d;
  logic [rlst_pkg::AddrW-1:0] pidx_q;
  logic                       issue;
  logic [rlst_pkg::AddrW-1:0] rd_addr;
  assign rd_addr = rd_idx_q[rlst_pkg::AddrW-1:0];

  // entry memory
  rlst_pkg::entry_t entry_mem [rlst_pkg::MaxLoads];
  rlst_pkg::entry_t ent_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_entry) begin
      entry_mem[wr_addr] <= wr_entry_data;
    end
    if (issue) begin
      ent_rd_q <= entry_mem[rd_addr];
    end
  end

  // status memory; an entry without its valid bit reads as undefined
  logic [1:0]                  sts_mem [rlst_pkg::MaxLoads];
  logic [rlst_pkg::MaxLoads-1:0] sts_vld_q;
  logic [1:0]                  sts_rd_q;
  logic                        sts_vld_rd_q;
  logic                        sts_we;
  logic [1:0]                  sts_wdata;
  logic [1:0]                  sts_eff;

  always_ff @(posedge clk_i) begin
    if (sts_we) begin
      sts_mem[pidx_q] <= sts_wdata;
    end
    if (issue) begin
      sts_rd_q <= sts_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sts_vld_q    <= '0;
      sts_vld_rd_q <= 1'b0;
    end else begin
      if (wr_entry) begin
        sts_vld_q[wr_addr] <= 1'b0;
      end
      if (sts_we) begin
        sts_vld_q[pidx_q] <= 1'b1;
      end
      if (issue) begin
        sts_vld_rd_q <= sts_vld_q[rd_addr];
      end
    end
  end

  assign sts_eff = sts_vld_rd_q ? sts_rd_q : rlst_pkg::StsUndef;

  // tick counters
  logic [7:0] start_cnt_q, start_cnt_d, wait_cnt_q, wait_cnt_d, wait_tgt_q, wait_tgt_d;
  logic [7:0] prev_node_q, prev_node_d, prev_group_q, prev_group_d;
  logic [7:0] start_nx, wait_nx;
  assign start_nx = (start_cnt_q < start_delay_q) ? start_cnt_q + 8'd1 : start_cnt_q;
  assign wait_nx  = (wait_cnt_q < retry_wait_q) ? wait_cnt_q + 8'd1 : wait_cnt_q;

  // scan accumulators
  logic matched_q, matched_d;   // frame hit any relay entry
  logic found_q, found_d;       // tick found an undefined entry
  logic seen_q, seen_d;         // query group has loads
  logic any_undef_q, any_undef_d;
  logic any_on_q, any_on_d;
  logic [7:0] pn_q, pn_d, pg_q, pg_d;

  // per-entry compare on the registered read data
  logic frame_hit, tick_hit, query_hit;
  assign frame_hit = pv_q && (mode_q == rlst_pkg::ModeFrame) && ent_rd_q.relay &&
                     (ent_rd_q.channel == chan_q) && (ent_rd_q.node == node_q) &&
                     (ent_rd_q.group == group_q);
  assign tick_hit  = pv_q && (mode_q == rlst_pkg::ModeTick) && !found_q &&
                     (sts_eff == rlst_pkg::StsUndef);
  assign query_hit = pv_q && (mode_q == rlst_pkg::ModeQuery) && (ent_rd_q.sm == sm_q);

  assign sts_we    = frame_hit && ((sbyte_q == rlst_pkg::ByteOff) ||
                                   (sbyte_q == rlst_pkg::ByteOn));
  assign sts_wdata = (sbyte_q == rlst_pkg::ByteOn) ? rlst_pkg::StsOn : rlst_pkg::StsOff;

  // tick stops at the first undefined entry
  assign issue = (state_q == rlst_pkg::StScan) && (rd_idx_q < n_act) &&
                 !found_q && !tick_hit;

  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    pv_d         = issue;
    matched_d    = matched_q;
    found_d      = found_q;
    seen_d       = seen_q;
    any_undef_d  = any_undef_q;
    any_on_d     = any_on_q;
    pn_d         = pn_q;
    pg_d         = pg_q;
    start_cnt_d  = start_cnt_q;
    wait_cnt_d   = wait_cnt_q;
    wait_tgt_d   = wait_tgt_q;
    prev_node_d  = prev_node_q;
    prev_group_d = prev_group_q;
    if (issue) begin
      rd_idx_d = rd_idx_q + rlst_pkg::CntW'(1);
    end
    case (state_q)
      rlst_pkg::StIdle: begin
        if (in_acc) begin
          rd_idx_d    = '0;
          pv_d        = 1'b0;
          matched_d   = 1'b0;
          found_d     = 1'b0;
          seen_d      = 1'b0;
          any_undef_d = 1'b0;
          any_on_d    = 1'b0;
          case (rlst_pkg::mode_e'(mode_i))
            rlst_pkg::ModeWrite: state_d = rlst_pkg::StDone;
            rlst_pkg::ModeFrame: state_d = is_relay_i ? rlst_pkg::StScan : rlst_pkg::StDone;
            rlst_pkg::ModeTick: begin
              start_cnt_d = start_nx;
              wait_cnt_d  = wait_nx;
              // polling allowed only once both delays are over
              state_d = ((start_nx >= start_delay_q) && (wait_nx >= wait_tgt_q)) ?
                        rlst_pkg::StScan : rlst_pkg::StDone;
            end
            rlst_pkg::ModeQuery: state_d = rlst_pkg::StScan;
            default: state_d = rlst_pkg::StDone;
          endcase
        end
      end
      rlst_pkg::StScan: begin
        if (frame_hit) begin
          matched_d = 1'b1;
        end
        if (tick_hit) begin
          found_d      = 1'b1;
          pn_d         = ent_rd_q.node;
          pg_d         = ent_rd_q.group;
          wait_cnt_d   = '0;
          // same target as last poll: back off with the long wait
          wait_tgt_d   = ((prev_node_q == ent_rd_q.node) &&
                          (prev_group_q == ent_rd_q.group)) ? retry_wait_q : normal_wait_q;
          prev_node_d  = ent_rd_q.node;
          prev_group_d = ent_rd_q.group;
        end
        if (query_hit) begin
          seen_d = 1'b1;
          if (sts_eff == rlst_pkg::StsUndef) begin
            any_undef_d = 1'b1;
          end
          if (sts_eff == rlst_pkg::StsOn) begin
            any_on_d = 1'b1;
          end
        end
        if (!issue && !pv_q) begin
          state_d = rlst_pkg::StDone;
        end
      end
      rlst_pkg::StDone: begin
        if (out_load) begin
          state_d = rlst_pkg::StIdle;
        end
      end
      default: state_d = rlst_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rlst_pkg::StIdle;
      rd_idx_q     <= '0;
      pv_q         <= 1'b0;
      matched_q    <= 1'b0;
      found_q      <= 1'b0;
      seen_q       <= 1'b0;
      any_undef_q  <= 1'b0;
      any_on_q     <= 1'b0;
      start_cnt_q  <= '0;
      wait_cnt_q   <= '0;
      wait_tgt_q   <= rlst_pkg::NormalWaitRst;
      prev_node_q  <= '0;
      prev_group_q <= '0;
    end else begin
      state_q      <= state_d;
      rd_idx_q     <= rd_idx_d;
      pv_q         <= pv_d;
      matched_q    <= matched_d;
      found_q      <= found_d;
      seen_q       <= seen_d;
      any_undef_q  <= any_undef_d;
      any_on_q     <= any_on_d;
      start_cnt_q  <= start_cnt_d;
      wait_cnt_q   <= wait_cnt_d;
      wait_tgt_q   <= wait_tgt_d;
      prev_node_q  <= prev_node_d;
      prev_group_q <= prev_group_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= rd_addr;
    pn_q   <= pn_d;
    pg_q   <= pg_d;
  end

  // result register
  logic       out_valid_q;
  logic [1:0] kind_q, gstat_q;
  logic [7:0] onode_q, ogroup_q;
  logic       omatch_q;
  logic [1:0] kind_d, gstat_d;
  logic [7:0] onode_d, ogroup_d;
  logic       omatch_d;

  always_comb begin
    kind_d   = rlst_pkg::KindNone;
    gstat_d  = rlst_pkg::StsUndef;
    onode_d  = '0;
    ogroup_d = '0;
    omatch_d = 1'b0;
    case (mode_q)
      rlst_pkg::ModeFrame: omatch_d = matched_q;
      rlst_pkg::ModeTick: begin
        if (found_q) begin
          kind_d   = rlst_pkg::KindPoll;
          onode_d  = pn_q;
          ogroup_d = pg_q;
        end
      end
      rlst_pkg::ModeQuery: begin
        kind_d = rlst_pkg::KindQuery;
        if (!seen_q) begin
          gstat_d = rlst_pkg::StsNone;
        end else if (any_undef_q) begin
          gstat_d = rlst_pkg::StsUndef;
        end else if (any_on_q) begin
          gstat_d = rlst_pkg::StsOn;
        end else begin
          gstat_d = rlst_pkg::StsOff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q   <= kind_d;
      gstat_q  <= gstat_d;
      onode_q  <= onode_d;
      ogroup_q <= ogroup_d;
      omatch_q <= omatch_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign poll_node_o     = onode_q;
  assign poll_group_o    = ogroup_q;
  assign group_status_o  = gstat_q;
  assign frame_matched_o = omatch_q;

endmodule

// ===== dv/load_tracker_checker.sv =====
module load_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  entry_index_i,
  input  logic [7:0]  node_i,
  input  logic [7:0]  group_i,
  input  logic [7:0]  channel_i,
  input  logic        is_relay_i,
  input  logic [15:0] sm_id_i,
  input  logic [7:0]  status_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  result_kind_i,
  input  logic [7:0]  poll_node_i,
  input  logic [7:0]  poll_group_i,
  input  logic [1:0]  group_status_i,
  input  logic        frame_matched_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] node;
    logic [7:0] group;
    logic [1:0] status;
    logic       matched;
  } answer_t;

  answer_t answers_due[$];
  answer_t want;

  // load table as the block should hold it
  logic [7:0]  tbl_node   [rlst_pkg::MaxLoads];
  logic [7:0]  tbl_group  [rlst_pkg::MaxLoads];
  logic [7:0]  tbl_chan   [rlst_pkg::MaxLoads];
  logic        tbl_relay  [rlst_pkg::MaxLoads];
  logic [15:0] tbl_sm     [rlst_pkg::MaxLoads];
  logic [1:0]  tbl_status [rlst_pkg::MaxLoads];

  logic [6:0] cfg_loads;
  logic [7:0] cfg_start, cfg_normal, cfg_retry;
  logic [7:0] start_cnt, wait_cnt, wait_tgt, prev_node, prev_group;

  initial fail_count_o = 0;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // applies one transaction to the table and returns the answer it must produce
  function automatic answer_t apply_transaction(input rlst_pkg::mode_e mode,
                                                input logic [5:0] idx,
                                                input logic [7:0] node, input logic [7:0] group,
                                                input logic [7:0] chan, input logic relay,
                                                input logic [15:0] sm, input logic [7:0] sbyte);
    answer_t ans;
    int n;
    int i;
    logic seen, any_undef, any_on;
    ans = '0;
    seen = 1'b0;
    any_undef = 1'b0;
    any_on = 1'b0;
    n = (int'(cfg_loads) > rlst_pkg::MaxLoads) ? rlst_pkg::MaxLoads : int'(cfg_loads);
    case (mode)
      rlst_pkg::ModeWrite: begin
        tbl_node[idx] = node;
        tbl_group[idx] = group;
        tbl_chan[idx] = chan;
        tbl_relay[idx] = relay;
        tbl_sm[idx] = sm;
        tbl_status[idx] = rlst_pkg::StsUndef;
      end
      rlst_pkg::ModeFrame: begin
        if (relay) begin
          for (i = 0; i < n; i++) begin
            if (tbl_relay[i] && tbl_chan[i] == chan && tbl_node[i] == node &&
                tbl_group[i] == group) begin
              if (sbyte == rlst_pkg::ByteOff) tbl_status[i] = rlst_pkg::StsOff;
              else if (sbyte == rlst_pkg::ByteOn) tbl_status[i] = rlst_pkg::StsOn;
              ans.matched = 1'b1;
            end
          end
        end
      end
      rlst_pkg::ModeTick: begin
        if (start_cnt < cfg_start) start_cnt++;
        if (wait_cnt < cfg_retry) wait_cnt++;
        if (start_cnt >= cfg_start && wait_cnt >= wait_tgt) begin
          for (i = 0; i < n && ans.kind == rlst_pkg::KindNone; i++) begin
            if (tbl_status[i] == rlst_pkg::StsUndef) begin
              ans.kind = rlst_pkg::KindPoll;
              ans.node = tbl_node[i];
              ans.group = tbl_group[i];
              wait_cnt = '0;
              wait_tgt = (prev_node == tbl_node[i] && prev_group == tbl_group[i]) ?
                         cfg_retry : cfg_normal;
              prev_node = tbl_node[i];
              prev_group = tbl_group[i];
            end
          end
        end
      end
      default: begin
        for (i = 0; i < n; i++) begin
          if (tbl_sm[i] == sm) begin
            seen = 1'b1;
            if (tbl_status[i] == rlst_pkg::StsUndef) any_undef = 1'b1;
            if (tbl_status[i] == rlst_pkg::StsOn) any_on = 1'b1;
          end
        end
        ans.kind = rlst_pkg::KindQuery;
        ans.status = !seen ? rlst_pkg::StsNone : any_undef ? rlst_pkg::StsUndef :
                     any_on ? rlst_pkg::StsOn : rlst_pkg::StsOff;
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rlst_pkg::MaxLoads; i++) begin
        tbl_node[i] = '0;
        tbl_group[i] = '0;
        tbl_chan[i] = '0;
        tbl_relay[i] = 1'b0;
        tbl_sm[i] = '0;
        tbl_status[i] = rlst_pkg::StsUndef;
      end
      cfg_loads = '0;
      cfg_start = rlst_pkg::StartDelayRst;
      cfg_normal = rlst_pkg::NormalWaitRst;
      cfg_retry = rlst_pkg::RetryWaitRst;
      start_cnt = '0;
      wait_cnt = '0;
      wait_tgt = rlst_pkg::NormalWaitRst;
      prev_node = '0;
      prev_group = '0;
      answers_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rlst_pkg::CfgLoadCount:  cfg_loads = cfg_data_i[6:0];
          rlst_pkg::CfgStartDelay: cfg_start = cfg_data_i;
          rlst_pkg::CfgNormalWait: cfg_normal = cfg_data_i;
          rlst_pkg::CfgRetryWait:  cfg_retry = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        answers_due.push_back(apply_transaction(rlst_pkg::mode_e'(mode_i), entry_index_i,
                                                node_i, group_i, channel_i, is_relay_i,
                                                sm_id_i, status_byte_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          report($sformatf("result kind %0d arrived with nothing pending", result_kind_i));
        end else begin
          want = answers_due.pop_front();
          if (result_kind_i !== want.kind)
            report($sformatf("result_kind %0d, expected %0d", result_kind_i, want.kind));
          if (poll_node_i !== want.node)
            report($sformatf("poll_node %0h, expected %0h", poll_node_i, want.node));
          if (poll_group_i !== want.group)
            report($sformatf("poll_group %0h, expected %0h", poll_group_i, want.group));
          if (group_status_i !== want.status)
            report($sformatf("group_status %0d, expected %0d", group_status_i, want.status));
          if (frame_matched_i !== want.matched)
            report($sformatf("frame_matched %0b, expected %0b", frame_matched_i,
                             want.matched));
        end
      end
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // generous cycle budget, far above the slowest legal run
  localparam int Limit       = 900000;
  localparam int PhaseItems  = 135;
  localparam int PhaseCount  = 8;

  typedef struct {
    rlst_pkg::mode_e mode;
    logic [5:0]      idx;
    logic [7:0]      node;
    logic [7:0]      group;
    logic [7:0]      chan;
    logic            relay;
    logic [15:0]     sm;
    logic [7:0]      sbyte;
  } txn_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic       cfg_we   = 1'b0;
  logic [1:0] cfg_idx  = '0;
  logic [7:0] cfg_data = '0;

  // input channel
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  mode        = '0;
  logic [5:0]  entry_index = '0;
  logic [7:0]  node        = '0;
  logic [7:0]  group       = '0;
  logic [7:0]  channel     = '0;
  logic        is_relay    = 1'b0;
  logic [15:0] sm_id       = '0;
  logic [7:0]  stat_byte   = '0;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] poll_node;
  logic [7:0] poll_group;
  logic [1:0] group_status;
  logic       frame_matched;

  int fail_count;
  int pending;
  int cycle_count;
  bit calm = 1'b0;  // no idling on either side while set

  // what has been written to each slot, so frames and queries can hit real entries
  logic [7:0]  slot_node  [rlst_pkg::MaxLoads];
  logic [7:0]  slot_group [rlst_pkg::MaxLoads];
  logic [7:0]  slot_chan  [rlst_pkg::MaxLoads];
  logic [15:0] slot_sm    [rlst_pkg::MaxLoads];

  relay_load_status_tracker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .entry_index_i   (entry_index),
    .node_i          (node),
    .group_i         (group),
    .channel_i       (channel),
    .is_relay_i      (is_relay),
    .sm_id_i         (sm_id),
    .status_byte_i   (stat_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_o   (result_kind),
    .poll_node_o     (poll_node),
    .poll_group_o    (poll_group),
    .group_status_o  (group_status),
    .frame_matched_o (frame_matched)
  );

  load_tracker_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .mode_i          (mode),
    .entry_index_i   (entry_index),
    .node_i          (node),
    .group_i         (group),
    .channel_i       (channel),
    .is_relay_i      (is_relay),
    .sm_id_i         (sm_id),
    .status_byte_i   (stat_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .result_kind_i   (result_kind),
    .poll_node_i     (poll_node),
    .poll_group_i    (poll_group),
    .group_status_i  (group_status),
    .frame_matched_i (frame_matched),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #5 clk_i = ~clk_i;

  // result side back-pressure, about a third of the cycles
  always @(negedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 33);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < Limit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // small value pool so node/group pairs and channels collide often
  function automatic logic [7:0] pool_byte();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic txn_t mk(input rlst_pkg::mode_e m, input logic [5:0] idx,
                              input logic [7:0] nd, input logic [7:0] gr,
                              input logic [7:0] ch, input logic rl,
                              input logic [15:0] sm, input logic [7:0] sb);
    txn_t t;
    t.mode = m;
    t.idx = idx;
    t.node = nd;
    t.group = gr;
    t.chan = ch;
    t.relay = rl;
    t.sm = sm;
    t.sbyte = sb;
    return t;
  endfunction

  // mostly well-formed traffic: frames and queries aimed at loaded entries
  function automatic txn_t random_txn();
    txn_t t;
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, rlst_pkg::MaxLoads - 1);
    t = mk(rlst_pkg::ModeTick, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
           16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    if (roll < 15) begin
      t.mode = rlst_pkg::ModeWrite;
      t.node = pool_byte();
      t.group = pool_byte();
      t.chan = pool_byte();
      t.relay = ($urandom_range(0, 9) < 8);
      if ($urandom_range(0, 9) < 8) t.sm = 16'($urandom_range(0, 3)) - 16'd2;
    end else if (roll < 45) begin
      t.mode = rlst_pkg::ModeFrame;
      if ($urandom_range(0, 9) < 7) begin
        t.node = slot_node[k];
        t.group = slot_group[k];
        t.chan = slot_chan[k];
        t.relay = 1'b1;
      end else begin
        t.node = pool_byte();
        t.group = pool_byte();
        t.chan = pool_byte();
      end
      case ($urandom_range(0, 4))
        0, 1:    t.sbyte = rlst_pkg::ByteOff;
        2, 3:    t.sbyte = rlst_pkg::ByteOn;
        default: ;
      endcase
    end else if (roll >= 80) begin
      t.mode = rlst_pkg::ModeQuery;
      if ($urandom_range(0, 3) != 0) t.sm = slot_sm[k];
    end
    return t;
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send(input txn_t t);
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    if (t.mode == rlst_pkg::ModeWrite) begin
      slot_node[t.idx] = t.node;
      slot_group[t.idx] = t.group;
      slot_chan[t.idx] = t.chan;
      slot_sm[t.idx] = t.sm;
    end
    in_valid    <= 1'b1;
    mode        <= t.mode;
    entry_index <= t.idx;
    node        <= t.node;
    group       <= t.group;
    channel     <= t.chan;
    is_relay    <= t.relay;
    sm_id       <= t.sm;
    stat_byte   <= t.sbyte;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  // registers only change with the block idle
  task automatic configure(input logic [7:0] loads, input logic [7:0] start_dly,
                           input logic [7:0] normal_wt, input logic [7:0] retry_wt);
    drain();
    cfg_write(rlst_pkg::CfgLoadCount, loads);
    cfg_write(rlst_pkg::CfgStartDelay, start_dly);
    cfg_write(rlst_pkg::CfgNormalWait, normal_wt);
    cfg_write(rlst_pkg::CfgRetryWait, retry_wt);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: query finds no loads, tick and frame do nothing
    send(mk(rlst_pkg::ModeQuery, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h8000, 8'hFF));
    send(mk(rlst_pkg::ModeTick, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h00));
    send(mk(rlst_pkg::ModeFrame, 6'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'h7FFF,
            rlst_pkg::ByteOn));

    // a few loads; slot 2 shares node/group with slot 0, slot 3 is not a relay
    send(mk(rlst_pkg::ModeWrite, 6'd0, 8'h00, 8'h00, 8'h00, 1'b1, 16'h8000, 8'h00));
    send(mk(rlst_pkg::ModeWrite, 6'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h7FFF, 8'hFF));
    send(mk(rlst_pkg::ModeWrite, 6'd2, 8'h00, 8'h00, 8'h07, 1'b1, 16'h8000, 8'h5A));
    send(mk(rlst_pkg::ModeWrite, 6'd3, 8'h12, 8'h34, 8'h03, 1'b0, 16'h0005, 8'h00));
    send(mk(rlst_pkg::ModeWrite, 6'd4, 8'h12, 8'h34, 8'h03, 1'b1, 16'h0005, 8'h00));
    send(mk(rlst_pkg::ModeWrite, 6'd5, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 8'h00));
    send(mk(rlst_pkg::ModeWrite, 6'd63, 8'hAA, 8'h55, 8'hC3, 1'b1, 16'h1234, 8'h00));

    configure(8'd6, 8'd2, 8'd0, 8'd3);

    // first poll hits the reset pair 0/0, so the long wait follows
    send(mk(rlst_pkg::ModeTick, 6'h2A, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h00));
    send(mk(rlst_pkg::ModeTick, 6'h15, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 8'hFF));
    send(mk(rlst_pkg::ModeQuery, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h8000, 8'h00));
    send(mk(rlst_pkg::ModeFrame, 6'h00, 8'h00, 8'h00, 8'h00, 1'b1, 16'h0000,
            rlst_pkg::ByteOn));
    send(mk(rlst_pkg::ModeFrame, 6'h00, 8'h00, 8'h00, 8'h07, 1'b1, 16'h0000,
            rlst_pkg::ByteOff));
    send(mk(rlst_pkg::ModeQuery, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h8000, 8'h00));
    // relay flag clear on the frame: nothing matches
    send(mk(rlst_pkg::ModeFrame, 6'h00, 8'h12, 8'h34, 8'h03, 1'b0, 16'h0000,
            rlst_pkg::ByteOff));
    // byte neither off nor on: match reported, status kept
    send(mk(rlst_pkg::ModeFrame, 6'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0000, 8'h5A));
    send(mk(rlst_pkg::ModeQuery, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h7FFF, 8'h00));
    send(mk(rlst_pkg::ModeFrame, 6'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0000,
            rlst_pkg::ByteOn));
    send(mk(rlst_pkg::ModeQuery, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h7FFF, 8'h00));
    send(mk(rlst_pkg::ModeQuery, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h1234, 8'h00));
    repeat (3) begin
      send(mk(rlst_pkg::ModeTick, 6'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h00));
    end

    // load every remaining slot so any load count reads written entries only
    for (int s = 6; s < rlst_pkg::MaxLoads; s++) begin
      send(mk(rlst_pkg::ModeWrite, 6'(s), pool_byte(), pool_byte(), pool_byte(),
              ($urandom_range(0, 9) < 8), 16'($urandom_range(0, 3)) - 16'd2,
              8'($urandom_range(0, 255))));
    end

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: configure(8'd64, 8'd0, 8'd0, 8'd0);
        1: configure(8'd127, 8'd255, 8'd255, 8'd255);  // count above the table size
        2: configure(8'd1, 8'd3, 8'd1, 8'd5);
        3: configure(8'd0, 8'd0, 8'd0, 8'd0);
        4: configure(8'd200, 8'd5, 8'd2, 8'd10);       // top bit outside the register
        default: configure(8'($urandom_range(0, 127)), 8'($urandom_range(0, 7)),
                           8'($urandom_range(0, 3)), 8'($urandom_range(0, 12)));
      endcase
      calm = (p == 6);
      for (int k = 0; k < PhaseItems; k++) begin
        // sender holds off until the block has answered everything
        if (p == 2 && k == 60) drain();
        send(random_txn());
      end
      calm = 1'b0;
    end

    drain();
    repeat (80) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rlst_pkg.sv
rtl/relay_load_status_tracker.sv
dv/load_tracker_checker.sv
dv/testbench.sv
